@@ design/ordered_list_engine_macros.svh @@
// Assertion macros shared by the ordered list engine.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define OLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/olist_pkg.sv @@
// Package for the ordered list engine: command and status codes, FSM states,
// the per-cell control struct and the stream widths. No dependencies.
`timescale 1ns / 1ps

package olist_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int S_DATA_W     = 40;  // command(2) + value(32), padded to bytes
  localparam int M_DATA_W     = 16;  // status(2) + position(4) + length(5), padded
  localparam int POS_W        = 4;
  localparam int LEN_W        = 5;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_END   = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_SEARCH    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_FULL      = 2'd3
  } sts_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic                       capture;    // latch match flags against cmp_value
    logic signed [VALUE_W-1:0]  cmp_value;
    logic                       shift_in;   // insert at front: take left neighbour
    logic                       append;     // insert at end: first empty cell loads
    logic                       close;      // delete: cells from the hit on take right
    logic signed [VALUE_W-1:0]  ins_value;
  } cell_ctl_t;

endpackage

@@ design/olist_cell.sv @@
// One cell of the ordered list chain: holds one entry and its valid flag.
// Depends on olist_pkg for the control struct.
`timescale 1ns / 1ps

module olist_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  olist_pkg::cell_ctl_t               ctl,
  input  logic signed [olist_pkg::VALUE_W-1:0] lft_data,
  input  logic                               lft_valid,
  input  logic signed [olist_pkg::VALUE_W-1:0] rgt_data,
  input  logic                               rgt_valid,
  input  logic                               hit_in,
  output logic signed [olist_pkg::VALUE_W-1:0] data,
  output logic                               valid,
  output logic                               hit_out,
  output logic                               first
);

  logic match;

  // Pass the hit chain on: a match here or upstream
  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;

  // Latch the compare result at command acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.capture) begin
      match <= valid && (data == ctl.cmp_value);
    end
  end

  // Update the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift_in) begin
      valid <= lft_valid;
    end else if (ctl.append && !valid && lft_valid) begin
      valid <= 1'b1;
    end else if (ctl.close && hit_out) begin
      valid <= rgt_valid;
    end
  end

  // Update the held entry
  always_ff @(posedge clk) begin
    if (ctl.shift_in) begin
      data <= lft_data;
    end else if (ctl.append && !valid && lft_valid) begin
      data <= ctl.ins_value;
    end else if (ctl.close && hit_out) begin
      data <= rgt_data;
    end
  end

endmodule

@@ design/ordered_list_engine.sv @@
// Ordered list engine: bounded list of signed 32-bit values with insert at
// front, insert at end, delete of the first match and search for it.
// Input stream s_tdata: [1:0] command, [33:2] value. Output stream m_tdata:
// [1:0] status, [5:2] position, [10:6] length after the command.
// Each command yields exactly one result transaction.
// A command accepted in the idle state is applied in the apply state, and its
// result is written to the output register when the output is free.
// The input takes no new command until the last one is applied. On acceptance
// every cell latches its compare against the value; in the apply state the
// first-match chain runs through the cells and they shift, all cells moving at once.
// Stall: while the output register holds an untaken result, a finished
// command waits in the apply cycle and the list is left unchanged; the input
// is not ready until that command has been written out.
// Reset (rst, synchronous, active high) empties the list and drops any
// pending result; no clearing pass is needed since cells carry valid flags.
// Depends on olist_pkg, olist_cell and ordered_list_engine_macros.svh.
`timescale 1ns / 1ps
`include "ordered_list_engine_macros.svh"

module ordered_list_engine #(
  parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [olist_pkg::S_DATA_W-1:0]  s_tdata,   // command, value
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [olist_pkg::M_DATA_W-1:0]  m_tdata    // status, position, length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  olist_pkg::state_t state, state_next;
  olist_pkg::cmd_t   cmd_q;
  logic signed [olist_pkg::VALUE_W-1:0] val_q;
  logic [CNT_W-1:0] count, count_next;

  olist_pkg::cell_ctl_t ctl;
  logic signed [olist_pkg::VALUE_W-1:0] data_arr [CAPACITY];
  logic signed [olist_pkg::VALUE_W-1:0] lft_data [CAPACITY];
  logic signed [olist_pkg::VALUE_W-1:0] rgt_data [CAPACITY];
  logic [CAPACITY-1:0] valid_vec, lft_valid, rgt_valid, first_vec;
  logic [CAPACITY:0]   hit_chain;

  logic accept, commit, full, found;
  logic [IDX_W-1:0] pos_idx;
  olist_pkg::sts_t status;
  logic [31:0] pos_wide, len_wide;
  logic [olist_pkg::POS_W-1:0] pos_field;
  logic [olist_pkg::LEN_W-1:0] len_field;

  assign accept = s_tvalid && s_tready;
  assign commit = (state == olist_pkg::S_APPLY) && (!m_tvalid || m_tready);
  assign full   = valid_vec[CAPACITY-1];
  assign found  = hit_chain[CAPACITY];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      olist_pkg::S_IDLE:  if (accept) state_next = olist_pkg::S_APPLY;
      olist_pkg::S_APPLY: if (commit) state_next = olist_pkg::S_IDLE;
      default:            state_next = olist_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    unique case (state)
      olist_pkg::S_IDLE: s_tready = 1'b1;
      default:           s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olist_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted command
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= olist_pkg::cmd_t'(s_tdata[1:0]);
      val_q <= s_tdata[33:2];
    end
  end

  // Broadcast control to the chain
  always_comb begin
    ctl.capture   = accept;
    ctl.cmp_value = s_tdata[33:2];
    ctl.shift_in  = commit && (cmd_q == olist_pkg::CMD_INS_FRONT) && !full;
    ctl.append    = commit && (cmd_q == olist_pkg::CMD_INS_END) && !full;
    ctl.close     = commit && (cmd_q == olist_pkg::CMD_DELETE) && found;
    ctl.ins_value = val_q;
  end

  // Chain of cells
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lft_data[i]  = val_q;
      assign lft_valid[i] = 1'b1;
    end else begin : g_body
      assign lft_data[i]  = data_arr[i-1];
      assign lft_valid[i] = valid_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rgt_data[i]  = data_arr[i];
      assign rgt_valid[i] = 1'b0;
    end else begin : g_next
      assign rgt_data[i]  = data_arr[i+1];
      assign rgt_valid[i] = valid_vec[i+1];
    end

    olist_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .lft_data  (lft_data[i]),
      .lft_valid (lft_valid[i]),
      .rgt_data  (rgt_data[i]),
      .rgt_valid (rgt_valid[i]),
      .hit_in    (hit_chain[i]),
      .data      (data_arr[i]),
      .valid     (valid_vec[i]),
      .hit_out   (hit_chain[i+1]),
      .first     (first_vec[i])
    );
  end

  // Encode the position of the first match
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_vec[i]) begin
        pos_idx = pos_idx | IDX_W'(i);
      end
    end
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (ctl.shift_in || ctl.append) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.close) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result status
  always_comb begin
    status = olist_pkg::STS_DONE;
    case (cmd_q)
      olist_pkg::CMD_INS_FRONT,
      olist_pkg::CMD_INS_END: if (full) status = olist_pkg::STS_FULL;
      olist_pkg::CMD_DELETE: begin
        if (!valid_vec[0]) begin
          status = olist_pkg::STS_EMPTY;
        end else if (!found) begin
          status = olist_pkg::STS_NOT_FOUND;
        end
      end
      default: if (!found) status = olist_pkg::STS_NOT_FOUND;
    endcase
  end

  // Mask position and length to their field widths
  assign pos_wide  = ((cmd_q == olist_pkg::CMD_SEARCH) && found) ? 32'(pos_idx) : 32'd0;
  assign len_wide  = 32'(count_next);
  assign pos_field = pos_wide[olist_pkg::POS_W-1:0];
  assign len_field = len_wide[olist_pkg::LEN_W-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {5'b0, len_field, pos_field, status};
    end
  end

  // Checks
  `OLE_ASSERT_SAME(a_count_matches_cells, 1'b1, $countones(valid_vec) == int'(count), "count disagrees with valid cells")
  `OLE_ASSERT_NEXT(a_insert_grows, (ctl.shift_in || ctl.append), count == $past(count) + CNT_W'(1), "insert did not grow list")
  `OLE_ASSERT_SAME(a_search_hit_valid, (commit && (cmd_q == olist_pkg::CMD_SEARCH) && found), valid_vec[pos_idx], "search hit an empty cell")

endmodule

@@ bench/tb_ordered_list_engine.sv @@
// Self-checking bench for ordered_list_engine: a directed stimulus table, then
// random command streams with a shadow list predicting each status transaction.
// Depends on olist_pkg and the ordered_list_engine RTL.
`timescale 1ns / 1ps

module tb_ordered_list_engine;

  localparam int DEPTH        = olist_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    olist_pkg::sts_t             status;
    logic [olist_pkg::POS_W-1:0] position;
    logic [olist_pkg::LEN_W-1:0] length;
  } list_result_t;

  typedef struct {
    olist_pkg::cmd_t               cmd;
    logic [olist_pkg::VALUE_W-1:0] value;
    bit                            typed;
    list_result_t                  result;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [olist_pkg::S_DATA_W-1:0] s_tdata = '0;   // command, value
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [olist_pkg::M_DATA_W-1:0] m_tdata;        // status, position, length

  // Shadow copy of the list
  logic [olist_pkg::VALUE_W-1:0]  held [DEPTH];
  int                             held_count = 0;

  list_result_t        pending_results [$];
  stim_row_t           stim_table [$];
  int                  errors = 0;
  int                  idle_cycles = 0;
  bit                  quiet = 1'b0;

  ordered_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Apply one command to the shadow list and return its status transaction
  function automatic list_result_t apply_command(input olist_pkg::cmd_t cmd,
                                                 input logic [olist_pkg::VALUE_W-1:0] v);
    list_result_t r;
    int hit;
    r.status   = olist_pkg::STS_DONE;
    r.position = '0;
    hit = held_count;
    for (int i = held_count - 1; i >= 0; i--)
      if (held[i] == v) hit = i;
    case (cmd)
      olist_pkg::CMD_INS_FRONT, olist_pkg::CMD_INS_END: begin
        if (held_count >= DEPTH) begin
          r.status = olist_pkg::STS_FULL;
        end else begin
          if (cmd == olist_pkg::CMD_INS_FRONT) begin
            for (int i = held_count; i > 0; i--) held[i] = held[i-1];
            held[0] = v;
          end else begin
            held[held_count] = v;
          end
          held_count++;
        end
      end
      olist_pkg::CMD_DELETE: begin
        if (held_count == 0) begin
          r.status = olist_pkg::STS_EMPTY;
        end else if (hit >= held_count) begin
          r.status = olist_pkg::STS_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < held_count; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      default: begin
        if (hit >= held_count) r.status = olist_pkg::STS_NOT_FOUND;
        else r.position = hit[olist_pkg::POS_W-1:0];
      end
    endcase
    r.length = held_count[olist_pkg::LEN_W-1:0];
    return r;
  endfunction

  function automatic olist_pkg::cmd_t pick_command(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 33) return olist_pkg::CMD_INS_FRONT;
      if (r < 65) return olist_pkg::CMD_INS_END;
      if (r < 80) return olist_pkg::CMD_DELETE;
      return olist_pkg::CMD_SEARCH;
    end
    if (r < 10) return olist_pkg::CMD_INS_FRONT;
    if (r < 20) return olist_pkg::CMD_INS_END;
    if (r < 75) return olist_pkg::CMD_DELETE;
    return olist_pkg::CMD_SEARCH;
  endfunction

  // Favour values already held so deletes and searches hit
  function automatic logic [olist_pkg::VALUE_W-1:0] pick_value();
    logic [olist_pkg::VALUE_W-1:0] pool [8];
    int r;
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h0000_0005, 32'h5555_5555, 32'hAAAA_AAAA};
    r = $urandom_range(0, 99);
    if (r < 40 && held_count > 0) return held[$urandom_range(0, held_count - 1)];
    if (r < 70) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic add_row(input olist_pkg::cmd_t cmd,
                         input logic [olist_pkg::VALUE_W-1:0] value,
                         input bit typed, input olist_pkg::sts_t sts,
                         input int pos, input int len);
    stim_row_t row;
    row.cmd             = cmd;
    row.value           = value;
    row.typed           = typed;
    row.result.status   = sts;
    row.result.position = pos[olist_pkg::POS_W-1:0];
    row.result.length   = len[olist_pkg::LEN_W-1:0];
    stim_table.push_back(row);
  endtask

  // Offer one transaction from a falling edge; return on the falling edge after acceptance
  task automatic send(input olist_pkg::cmd_t cmd,
                      input logic [olist_pkg::VALUE_W-1:0] value,
                      input bit typed, input list_result_t typed_result);
    int gap;
    list_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(olist_pkg::S_DATA_W-olist_pkg::VALUE_W-2){1'b0}}, value, cmd};
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    predicted = apply_command(cmd, value);
    pending_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: stall a random number of cycles before each transaction
  initial begin
    int gap;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (rst || !(m_tvalid && m_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d position %0d length %0d",
                 $time, m_tdata[1:0], m_tdata[5:2], m_tdata[10:6]);
      end else begin
        want = pending_results.pop_front();
        check_field("status",   want.status,   m_tdata[1:0]);
        check_field("position", want.position, m_tdata[5:2]);
        check_field("length",   want.length,   m_tdata[10:6]);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
  end

  initial begin
    bit filling;
    list_result_t none;
    none = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty list, extremes, filling to capacity, refused inserts, first match
    add_row(olist_pkg::CMD_SEARCH,    32'h0000_0000, 1, olist_pkg::STS_NOT_FOUND, 0, 0);
    add_row(olist_pkg::CMD_DELETE,    32'h0000_0000, 1, olist_pkg::STS_EMPTY,     0, 0);
    add_row(olist_pkg::CMD_INS_FRONT, 32'h7FFF_FFFF, 1, olist_pkg::STS_DONE,      0, 1);
    add_row(olist_pkg::CMD_INS_END,   32'h8000_0000, 1, olist_pkg::STS_DONE,      0, 2);
    add_row(olist_pkg::CMD_INS_FRONT, 32'hFFFF_FFFF, 1, olist_pkg::STS_DONE,      0, 3);
    add_row(olist_pkg::CMD_INS_END,   32'h0000_0000, 1, olist_pkg::STS_DONE,      0, 4);
    add_row(olist_pkg::CMD_SEARCH,    32'h8000_0000, 0, olist_pkg::STS_DONE,      0, 0);
    add_row(olist_pkg::CMD_SEARCH,    32'h0000_0001, 0, olist_pkg::STS_DONE,      0, 0);
    for (int k = 0; k < 12; k++)
      add_row(k[0] ? olist_pkg::CMD_INS_END : olist_pkg::CMD_INS_FRONT,
              (k == 11) ? 32'h1357_9BDF : (k % 3 == 0) ? 32'h0000_0005 : 32'h5555_5555 ^ k,
              1, olist_pkg::STS_DONE, 0, 5 + k);
    add_row(olist_pkg::CMD_INS_FRONT, 32'h0000_0001, 1, olist_pkg::STS_FULL,      0, DEPTH);
    add_row(olist_pkg::CMD_INS_END,   32'h0000_0001, 1, olist_pkg::STS_FULL,      0, DEPTH);
    add_row(olist_pkg::CMD_SEARCH,    32'h1357_9BDF, 0, olist_pkg::STS_DONE,      0, 0);
    add_row(olist_pkg::CMD_SEARCH,    32'h0000_0005, 0, olist_pkg::STS_DONE,      0, 0);
    add_row(olist_pkg::CMD_DELETE,    32'h0000_0005, 0, olist_pkg::STS_DONE,      0, 0);
    add_row(olist_pkg::CMD_DELETE,    32'h1234_5678, 1, olist_pkg::STS_NOT_FOUND, 0,
            DEPTH - 1);

    foreach (stim_table[k])
      send(stim_table[k].cmd, stim_table[k].value, stim_table[k].typed,
           stim_table[k].result);
    pause_until_drained();

    // Random part: swing between filling and draining so both ends are reached
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n % 250 == 249) pause_until_drained();
      if (held_count >= DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (held_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) == 0) filling = !filling;
      send(pick_command(filling), pick_value(), 1'b0, none);
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then allow for late extras
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
